// ===== rtl/ostt_pkg.sv =====
package ostt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int DELAY_BITS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ID_W       = 4;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_HALT   = 2'd3;

  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] timer_id;
    logic [15:0]     delay_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] timer_id_res;
    logic            ok;
    logic            last;
  } out_beat_t;

  typedef struct packed {
    logic capture;
    logic sweep_step;
    logic emit;
    logic do_add;
    logic do_cancel;
    logic do_halt;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       halted;
    logic       sweep_done;
    logic       pend_any;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/one_shot_timer_table.sv =====
// Table of one-shot timers, one slot per id, driven by a command stream.
// Input channel (in_valid/in_ready/in_data) carries tick, add, cancel and halt
// beats; output channel (out_valid/out_ready/out_data) carries add status,
// cancel status and expiry beats, with last set on the final beat of a command.
// One command is in flight at a time: in_ready is high only while idle.
// Add and cancel: the command is captured, then once the output register is free
// the result is registered as the table returns to idle.
// Halt: no result; sets the halt flag and returns to idle.
// Tick: a countdown sweep visits all NUM_TIMERS slots, one slot per cycle, then
// one expiry beat per cycle while the output register is free, in
// earliest-deadline order, lowest id on ties. A tick while halted
// or with nothing firing gives no beat.
// A single output register holds the last result; when the receiver stalls
// the controller holds back the next result until that register drains.
// Reset (rst, synchronous) disarms every slot, clears halt and empties the
// output register.
module one_shot_timer_table import ostt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  ostt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ostt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !stat.pend_any)
    else $error("command accepted while expiries still pending");

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (stat.out_free && stat.pend_any))
    else $error("expiry issued without free output register or pending slot");

  a_expiry_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_EXPIRY) |-> out_data.ok)
    else $error("expiry beat without ok");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.cmd == CMD_HALT) |-> ##2 stat.halted)
    else $error("halt command did not halt the table");

endmodule

// ===== rtl/ostt_datapath.sv =====
module ostt_datapath import ostt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_beat_t  in_data,
  input  ctl_cmd_t  ctl,
  output dp_stat_t  stat,
  input  logic      out_ready,
  output logic      out_valid,
  output out_beat_t out_data
);

  logic [NUM_TIMERS-1:0] armed;
  logic [NUM_TIMERS-1:0] pend0;
  logic [NUM_TIMERS-1:0] pend1;
  logic [DELAY_BITS-1:0] remaining [NUM_TIMERS];
  logic                  halted;
  in_beat_t              held;
  logic [IDX_W-1:0]      cnt;

  logic                  id_ok;
  logic [IDX_W-1:0]      id_idx;
  logic                  add_ok;
  logic [DELAY_BITS-1:0] rem_rd;
  logic                  arm_rd;
  logic [NUM_TIMERS-1:0] sel;
  logic [NUM_TIMERS-1:0] lowbit;
  logic [IDX_W-1:0]      low_idx;
  logic                  last_hit;
  logic                  load;

  assign id_ok  = 32'(held.timer_id) < 32'(NUM_TIMERS);
  assign id_idx = IDX_W'(held.timer_id);
  assign add_ok = !halted && id_ok;
  assign rem_rd = remaining[cnt];
  assign arm_rd = armed[cnt];

  // slots already at zero before the tick fire first, then those that just got there
  assign sel      = (pend0 != '0) ? pend0 : pend1;
  assign lowbit   = sel & (~sel + NUM_TIMERS'(1));
  assign last_hit = ((pend0 | pend1) & ~lowbit) == '0;
  assign load     = ctl.do_add | ctl.do_cancel | ctl.emit;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (lowbit[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= '0;
      pend0     <= '0;
      pend1     <= '0;
      halted    <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.capture) begin
        cnt <= '0;
      end
      if (ctl.sweep_step) begin
        pend0[cnt] <= arm_rd && (rem_rd == '0);
        pend1[cnt] <= arm_rd && (rem_rd == DELAY_BITS'(1));
        // drop the slot now when it fires; its beat goes out in the emit phase
        armed[cnt] <= arm_rd && (rem_rd > DELAY_BITS'(1));
        cnt        <= cnt + IDX_W'(1);
      end
      if (ctl.do_add && add_ok) begin
        armed[id_idx] <= 1'b1;
      end
      if (ctl.do_cancel && id_ok) begin
        armed[id_idx] <= 1'b0;
      end
      if (ctl.do_halt) begin
        halted <= 1'b1;
      end
      if (ctl.emit) begin
        pend0 <= pend0 & ~lowbit;
        pend1 <= pend1 & ~lowbit;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      held <= in_data;
    end
    if (ctl.sweep_step && arm_rd && (rem_rd != '0)) begin
      remaining[cnt] <= rem_rd - DELAY_BITS'(1);
    end
    if (ctl.do_add && add_ok) begin
      remaining[id_idx] <= DELAY_BITS'(held.delay_ms);
    end
    if (ctl.do_add) begin
      out_data <= '{kind: KIND_ADD, timer_id_res: held.timer_id, ok: add_ok, last: 1'b1};
    end else if (ctl.do_cancel) begin
      out_data <= '{kind: KIND_CANCEL, timer_id_res: held.timer_id,
                    ok: id_ok && armed[id_idx], last: 1'b1};
    end else if (ctl.emit) begin
      out_data <= '{kind: KIND_EXPIRY, timer_id_res: ID_W'(low_idx), ok: 1'b1,
                    last: last_hit};
    end
  end

  assign stat.cmd        = held.cmd;
  assign stat.halted     = halted;
  assign stat.sweep_done = cnt == IDX_W'(NUM_TIMERS - 1);
  assign stat.pend_any   = (pend0 | pend1) != '0;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/ostt_ctrl.sv =====
module ostt_ctrl import ostt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_RUN;
        end
      end
      S_RUN: begin
        unique case (stat.cmd)
          CMD_TICK: begin
            state_next = stat.halted ? S_IDLE : S_SWEEP;
          end
          CMD_ADD: begin
            if (stat.out_free) begin
              ctl.do_add = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_CANCEL: begin
            if (stat.out_free) begin
              ctl.do_cancel = 1'b1;
              state_next    = S_IDLE;
            end
          end
          CMD_HALT: begin
            ctl.do_halt = 1'b1;
            state_next  = S_IDLE;
          end
        endcase
      end
      S_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (stat.sweep_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.pend_any) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          ctl.emit = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
